/* rtl/uart_command_line_decoder_top_defines.svh */
// Assertion macros for the command line decoder RTL.
// No dependencies; pulled in by ucld_back, the module that carries checks.
`ifndef UART_COMMAND_LINE_DECODER_TOP_DEFINES_SVH
`define UART_COMMAND_LINE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define UCLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ucld check failed");

// Next-cycle implication, masked while reset is low.
`define UCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ucld check failed");

`endif

/* rtl/ucld_pkg.sv */
// Shared types, response codes and keyword tables for the command line decoder.
// No dependencies.
`default_nettype none

package ucld_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int TOKEN_LIMIT_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [2:0] RESP_HELP     = 3'd0;
    localparam logic [2:0] RESP_STATUS   = 3'd1;
    localparam logic [2:0] RESP_LED_DONE = 3'd2;
    localparam logic [2:0] RESP_TOO_LONG = 3'd3;
    localparam logic [2:0] RESP_UNKNOWN  = 3'd4;
    localparam logic [2:0] RESP_BAD_ARGS = 3'd5;

    localparam logic [2:0] TOKEN_POS_MAX = 3'd7;

    typedef enum logic [2:0] {
        CLS_TERM,
        CLS_BLANK,
        CLS_HASH,
        CLS_SLASH,
        CLS_OTHER
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic [7:0]  ch;    // upper-case folded
    } t_item;

    typedef enum logic {
        LINE_IDLE,
        LINE_RECV
    } t_line_state;

    typedef enum logic [1:0] {
        WORD_NONE,
        WORD_FIRST,
        WORD_SECOND
    } t_word;

    // Keyword tables, zero padded; a folded non-zero byte never matches padding.
    localparam logic [7:0] FIRST_WORDS [3][8] = '{
        '{"H", "E", "L", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "T", "U",   "S",   8'h00, 8'h00},
        '{"L", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] FIRST_LENS [3] = '{3'd4, 3'd6, 3'd3};

    localparam logic [7:0] SECOND_WORDS [3][8] = '{
        '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "O", "G", "G", "L",   "E",   8'h00, 8'h00}
    };
    localparam logic [2:0] SECOND_LENS [3] = '{3'd2, 3'd3, 3'd6};

    function automatic logic [2:0] narrow_first_char(logic [2:0] cands, logic [2:0] pos,
                                                     logic [7:0] ch);
        logic [2:0] res;
        res = cands;
        for (int k = 0; k < 3; k++) begin
            if (pos >= FIRST_LENS[k] || FIRST_WORDS[k][pos] != ch) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] narrow_second_char(logic [2:0] cands, logic [2:0] pos,
                                                      logic [7:0] ch);
        logic [2:0] res;
        res = cands;
        for (int k = 0; k < 3; k++) begin
            if (pos >= SECOND_LENS[k] || SECOND_WORDS[k][pos] != ch) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] narrow_first_len(logic [2:0] cands, logic [2:0] pos);
        logic [2:0] res;
        res = cands;
        for (int k = 0; k < 3; k++) begin
            if (pos != FIRST_LENS[k]) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] narrow_second_len(logic [2:0] cands, logic [2:0] pos);
        logic [2:0] res;
        res = cands;
        for (int k = 0; k < 3; k++) begin
            if (pos != SECOND_LENS[k]) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/ucld_front.sv */
// Input side: takes bytes, drops zero bytes, classifies and folds the rest.
// Depends on ucld_pkg.
`default_nettype none

module ucld_front
    import ucld_pkg::*;
(
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_item           o_item
);

    always_comb begin
        o_in_ready = !i_q_full;
        o_push     = i_in_valid && !i_q_full && (i_rx_byte != 8'h00);

        if (i_rx_byte == 8'h0D || i_rx_byte == 8'h0A) begin
            o_item.cls = CLS_TERM;
        end else if (i_rx_byte == 8'h20 || i_rx_byte == 8'h09) begin
            o_item.cls = CLS_BLANK;
        end else if (i_rx_byte == "#") begin
            o_item.cls = CLS_HASH;
        end else if (i_rx_byte == "/") begin
            o_item.cls = CLS_SLASH;
        end else begin
            o_item.cls = CLS_OTHER;
        end

        if (i_rx_byte >= "a" && i_rx_byte <= "z") begin
            o_item.ch = i_rx_byte - 8'd32;
        end else begin
            o_item.ch = i_rx_byte;
        end
    end

endmodule

`default_nettype wire

/* rtl/ucld_queue.sv */
// Small FIFO of classified bytes between the front and back ends.
// Depends on ucld_pkg.
`default_nettype none

module ucld_queue
    import ucld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/ucld_back.sv */
// Back end: line assembly, keyword matching, LED bit and the result register.
// Depends on ucld_pkg and the assertion macro header.
`default_nettype none
`include "uart_command_line_decoder_top_defines.svh"

module ucld_back
    import ucld_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int TOKEN_LIMIT   = TOKEN_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_item      i_q_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_response,
    output logic            o_led_level
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int TOK_W = $clog2(TOKEN_LIMIT + 1);

    t_line_state       r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_comment, n_comment;
    logic              r_slash, n_slash;
    logic [TOK_W-1:0]  r_tok, n_tok;
    logic              r_inside, n_inside;
    logic [2:0]        r_pos, n_pos;
    logic [2:0]        r_fc, n_fc;
    logic [2:0]        r_sc, n_sc;
    logic              r_led, n_led;
    t_word             r_active, n_active;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_resp, n_resp;

    logic              start, take, finish, close_tok, load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= LINE_IDLE;
            r_len       <= '0;
            r_comment   <= 1'b0;
            r_slash     <= 1'b0;
            r_tok       <= '0;
            r_inside    <= 1'b0;
            r_pos       <= '0;
            r_fc        <= 3'b111;
            r_sc        <= 3'b111;
            r_led       <= 1'b0;
            r_active    <= WORD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_comment   <= n_comment;
            r_slash     <= n_slash;
            r_tok       <= n_tok;
            r_inside    <= n_inside;
            r_pos       <= n_pos;
            r_fc        <= n_fc;
            r_sc        <= n_sc;
            r_led       <= n_led;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_comment = r_comment;
        n_slash   = r_slash;
        n_tok     = r_tok;
        n_inside  = r_inside;
        n_pos     = r_pos;
        n_fc      = r_fc;
        n_sc      = r_sc;
        n_led     = r_led;
        n_active  = r_active;
        n_resp    = r_resp;
        start     = 1'b0;
        take      = 1'b0;
        finish    = 1'b0;
        close_tok = 1'b0;
        load      = 1'b0;

        o_pop = i_q_valid && (!r_out_valid || i_out_ready);

        if (o_pop) begin
            case (r_state)
                LINE_IDLE: begin
                    if (i_q_item.cls != CLS_TERM) begin
                        start = 1'b1;
                        take  = 1'b1;
                    end
                end
                LINE_RECV: begin
                    if (i_q_item.cls == CLS_TERM) begin
                        finish = 1'b1;
                    end else if (r_len >= LEN_W'(LINE_CAPACITY - 1)) begin
                        // overflowing byte is dropped, next non-terminator byte opens a new line
                        n_state = LINE_IDLE;
                        load    = 1'b1;
                        n_resp  = RESP_TOO_LONG;
                    end else begin
                        take = 1'b1;
                    end
                end
                default: begin
                    n_state = LINE_IDLE;
                end
            endcase
        end

        if (start) begin
            n_state   = LINE_RECV;
            n_len     = '0;
            n_comment = 1'b0;
            n_slash   = 1'b0;
            n_tok     = '0;
            n_inside  = 1'b0;
            n_pos     = '0;
            n_fc      = 3'b111;
            n_sc      = 3'b111;
            n_active  = WORD_NONE;
        end

        if (take) begin
            if (n_len == '0) begin
                if (i_q_item.cls == CLS_HASH) begin
                    n_comment = 1'b1;
                end else if (i_q_item.cls == CLS_SLASH) begin
                    n_slash = 1'b1;
                end
            end else if (n_len == LEN_W'(1) && n_slash && i_q_item.cls == CLS_SLASH) begin
                n_comment = 1'b1;
            end
            n_len = n_len + 1'b1;

            if (i_q_item.cls == CLS_BLANK) begin
                close_tok = 1'b1;
            end else begin
                if (!n_inside) begin
                    n_inside = 1'b1;
                    n_pos    = '0;
                    n_active = WORD_NONE;
                    if (n_tok < TOK_W'(TOKEN_LIMIT)) begin
                        n_tok = n_tok + 1'b1;
                        if (n_tok == TOK_W'(1)) begin
                            n_active = WORD_FIRST;
                        end else if (n_tok == TOK_W'(2)) begin
                            n_active = WORD_SECOND;
                        end
                    end
                end
                if (n_active == WORD_FIRST) begin
                    n_fc = narrow_first_char(n_fc, n_pos, i_q_item.ch);
                end else if (n_active == WORD_SECOND) begin
                    n_sc = narrow_second_char(n_sc, n_pos, i_q_item.ch);
                end
                if (n_pos != TOKEN_POS_MAX) begin
                    n_pos = n_pos + 1'b1;
                end
            end
        end

        if (finish) begin
            close_tok = 1'b1;
        end

        if (close_tok && n_inside) begin
            if (n_active == WORD_FIRST) begin
                n_fc = narrow_first_len(n_fc, n_pos);
            end else if (n_active == WORD_SECOND) begin
                n_sc = narrow_second_len(n_sc, n_pos);
            end
            n_inside = 1'b0;
            n_active = WORD_NONE;
        end

        if (finish) begin
            n_state = LINE_IDLE;
            if (!n_comment && n_tok != '0) begin
                load = 1'b1;
                if (n_fc[0]) begin
                    n_resp = RESP_HELP;
                end else if (n_fc[1]) begin
                    n_resp = RESP_STATUS;
                end else if (n_fc[2]) begin
                    if (n_tok != TOK_W'(2)) begin
                        n_resp = RESP_BAD_ARGS;
                    end else if (n_sc[0]) begin
                        n_led  = 1'b1;
                        n_resp = RESP_LED_DONE;
                    end else if (n_sc[1]) begin
                        n_led  = 1'b0;
                        n_resp = RESP_LED_DONE;
                    end else if (n_sc[2]) begin
                        n_led  = !n_led;
                        n_resp = RESP_LED_DONE;
                    end else begin
                        n_resp = RESP_BAD_ARGS;
                    end
                end else begin
                    n_resp = RESP_UNKNOWN;
                end
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_response  = r_resp;
    assign o_led_level = r_led;

    `UCLD_ASSERT_NOW(a_resp_code, i_clk, i_rst_n, r_out_valid, r_resp <= RESP_BAD_ARGS)
    `UCLD_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(LINE_CAPACITY - 1))
    `UCLD_ASSERT_NOW(a_tok_bound, i_clk, i_rst_n, 1'b1, r_tok <= TOK_W'(TOKEN_LIMIT))
    `UCLD_ASSERT_NOW(a_word_in_token, i_clk, i_rst_n, r_active != WORD_NONE, r_inside)
    `UCLD_ASSERT_NOW(a_led_only_on_done, i_clk, i_rst_n, !$stable(r_led), r_out_valid && r_resp == RESP_LED_DONE)

endmodule

`default_nettype wire

/* rtl/uart_command_line_decoder_top.sv */
// Command line decoder for a received byte stream.
// Channels: input byte i_rx_byte on i_in_valid/o_in_ready; result request
//   o_response/o_led_level on o_out_valid/i_out_ready.
// A zero byte is taken and dropped. CR or LF ends a line; a line that
//   answers yields one result: 0 help, 1 LED status, 2 LED done,
//   3 line too long, 4 unknown command, 5 bad arguments.
// Throughput: one byte per cycle sustained while the receiver does not stall.
// Result path: with the queue empty and the result register free, the
//   terminating byte of a line is written into the queue when accepted,
//   then decoded into the result register, which drives o_out_valid.
// A QUEUE_DEPTH-entry queue separates the byte classifier from the line
//   decoder. While the receiver stalls, the result register holds, the
//   decoder stops draining the queue, and o_in_ready drops once it is full.
// Reset (i_rst_n low, synchronous): queue empty, between lines, LED off,
//   no result pending.
// Depends on ucld_pkg, ucld_front, ucld_queue, ucld_back.
`default_nettype none

module uart_command_line_decoder_top
    import ucld_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int TOKEN_LIMIT   = TOKEN_LIMIT_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_response,
    output logic            o_led_level
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_item push_item;
    t_item pop_item;

    ucld_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (push_item)
    );

    ucld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    ucld_back #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .TOKEN_LIMIT   (TOKEN_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (pop_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_response  (o_response),
        .o_led_level (o_led_level)
    );

endmodule

`default_nettype wire
